[rtl/hbd_pkg.sv]
`timescale 1ns / 1ps
// Package for the HDLC bit deframer: frame phases, result kinds, register
// indexes, shared structs and the CRC-16/X.25 byte update. No dependencies.
package hbd_pkg;

  localparam int LEN_BITS = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FLAG_OCTET = 8'h7E;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [11:0] MIN_FRAME_RESET = 12'd17;
  localparam logic [11:0] MAX_FRAME_RESET = 12'd400;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAGS,
    PH_DATA,
    PH_LAST,
    PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_CRC  = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_SCRAMBLE_ENABLE = 2'd0,
    REG_MIN_FRAME_BYTES = 2'd1,
    REG_MAX_FRAME_BYTES = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        scramble_enable;
    logic [11:0] min_frame_bytes;
    logic [11:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic bit_val;
  } bit_beat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/hbd_cfg.sv]
`timescale 1ns / 1ps
// APB register block of the HDLC bit deframer.
// Depends on hbd_pkg for the register indexes and the cfg_t struct.
module hbd_cfg import hbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = reg_index_t'(paddr[3:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scramble_enable <= 1'b0;
      cfg_r.min_frame_bytes <= MIN_FRAME_RESET;
      cfg_r.max_frame_bytes <= MAX_FRAME_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SCRAMBLE_ENABLE: cfg_r.scramble_enable <= pwdata[0];
        REG_MIN_FRAME_BYTES: cfg_r.min_frame_bytes <= pwdata[11:0];
        REG_MAX_FRAME_BYTES: cfg_r.max_frame_bytes <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCRAMBLE_ENABLE: prdata = {31'd0, cfg_r.scramble_enable};
      REG_MIN_FRAME_BYTES: prdata = {20'd0, cfg_r.min_frame_bytes};
      REG_MAX_FRAME_BYTES: prdata = {20'd0, cfg_r.max_frame_bytes};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

[rtl/hbd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts line bits, applies G3RUH descrambling when scramble_enable is set and NRZI decoding,
// and pushes decoded bits into the queue. Depends on hbd_pkg.
module hbd_front import hbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      scramble_enable,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_line_bit,
  input  logic      queue_full,
  output bit_beat_t push
);

  logic [16:0] shift_r, shift_nxt;
  logic        prev_r, prev_nxt;
  logic        descr_bit;
  logic        dec_bit;
  logic        accept;

  assign in_ready = ~queue_full;
  assign accept = in_valid & in_ready;
  assign descr_bit = in_line_bit ^ shift_r[11] ^ shift_r[16];
  assign dec_bit = scramble_enable ? descr_bit : in_line_bit;

  always_comb begin
    shift_nxt = shift_r;
    prev_nxt = prev_r;
    if (accept) begin
      if (scramble_enable) begin
        shift_nxt = {shift_r[15:0], in_line_bit};
      end
      prev_nxt = dec_bit;
    end
  end

  assign push.valid = accept;
  assign push.bit_val = (prev_r == dec_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      prev_r <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

[rtl/hbd_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of decoded bits between the front end and the framer.
// Depends on hbd_pkg for its depth and the bit_beat_t struct.
module hbd_queue import hbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bit_beat_t push,
  input  logic      pop,
  output logic      full,
  output bit_beat_t head
);

  logic [QUEUE_DEPTH-1:0] mem_r;
  logic [QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]      count_r, count_nxt;
  logic                   do_pop;

  assign full = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.bit_val = mem_r[rd_ptr_r];
  assign do_pop = pop & head.valid;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.bit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/hbd_back.sv]
`timescale 1ns / 1ps
// Framer back end: flag hunt, destuffing, byte assembly, FCS delay, CRC check
// and the registered result beat. Depends on hbd_pkg.
module hbd_back import hbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  bit_beat_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_frame_length
);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          flag_r, flag_nxt;
  logic [3:0]          bcnt_r, bcnt_nxt;
  logic [2:0]          ones_r, ones_nxt;
  logic [7:0]          asm_r, asm_nxt;
  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic [7:0]          held0_r, held0_nxt, held1_r, held1_nxt;
  logic [15:0]         crc_r, crc_nxt;

  logic                ovalid_r;
  kind_t               okind_r;
  logic [7:0]          obyte_r;
  logic [11:0]         olen_r;

  logic                step;
  logic                r;
  logic [7:0]          flag_sh, asm_sh;
  logic [3:0]          bcnt_inc;
  logic [LEN_BITS:0]   n_count;
  logic                overflow;
  logic                short_frame;
  logic                crc_ok;
  logic [LEN_BITS-1:0] pay_len;
  logic                emit;
  kind_t               ekind;
  logic [7:0]          ebyte;
  logic [11:0]         elen;

  assign pop = ~ovalid_r | out_ready;
  assign step = pop & head.valid;
  assign r = head.bit_val;
  assign flag_sh = {r, flag_r[7:1]};
  assign asm_sh = {r, asm_r[7:1]};
  assign bcnt_inc = bcnt_r + 1'b1;
  assign n_count = {1'b0, count_r} + 1'b1;
  assign overflow = (32'(n_count) > 32'(cfg.max_frame_bytes)) || n_count[LEN_BITS];
  assign short_frame = (count_r < LEN_BITS'(2))
                       || (32'(count_r) < 32'(cfg.min_frame_bytes));
  assign crc_ok = ({held1_r, held0_r} == (crc_r ^ 16'hFFFF));
  assign pay_len = (count_r >= LEN_BITS'(2)) ? count_r - LEN_BITS'(2) : '0;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_HUNT: begin
          if (flag_sh == FLAG_OCTET) phase_nxt = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (bcnt_inc == 4'd8 && flag_sh != FLAG_OCTET) phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          if (ones_r >= 3'd5) begin
            if (r) phase_nxt = PH_LAST;
          end else if (bcnt_inc == 4'd8 && overflow) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LAST: phase_nxt = PH_TAIL;
        PH_TAIL: begin
          if (bcnt_inc >= 4'd8 && flag_sh != FLAG_OCTET) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    flag_nxt = flag_r;
    bcnt_nxt = bcnt_r;
    ones_nxt = ones_r;
    asm_nxt = asm_r;
    count_nxt = count_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    crc_nxt = crc_r;
    emit = 1'b0;
    ekind = KIND_DATA;
    ebyte = 8'd0;
    elen = 12'd0;
    if (step) begin
      case (phase_r)
        PH_HUNT: begin
          flag_nxt = flag_sh;
          if (flag_sh == FLAG_OCTET) bcnt_nxt = 4'd0;
        end
        PH_FLAGS: begin
          flag_nxt = flag_sh;
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc == 4'd8) begin
            bcnt_nxt = 4'd0;
            if (flag_sh != FLAG_OCTET) begin
              held0_nxt = flag_sh;
              count_nxt = LEN_BITS'(1);
              ones_nxt = 3'd0;
              asm_nxt = 8'd0;
              crc_nxt = CRC_INIT;
            end
          end
        end
        PH_DATA: begin
          if (ones_r >= 3'd5) begin
            ones_nxt = 3'd0;
            if (r) begin
              emit = 1'b1;
              elen = 12'(pay_len);
              if (short_frame) ekind = KIND_SHORT;
              else if (crc_ok) ekind = KIND_GOOD;
              else ekind = KIND_BAD_CRC;
            end
          end else begin
            ones_nxt = r ? ones_r + 1'b1 : 3'd0;
            asm_nxt = asm_sh;
            bcnt_nxt = bcnt_inc;
            if (bcnt_inc == 4'd8) begin
              bcnt_nxt = 4'd0;
              asm_nxt = 8'd0;
              if (overflow) begin
                flag_nxt = 8'd0;
                ones_nxt = 3'd0;
                emit = 1'b1;
                ekind = KIND_OVERFLOW;
                elen = 12'(pay_len);
              end else begin
                count_nxt = n_count[LEN_BITS-1:0];
                held1_nxt = asm_sh;
                if (count_r >= LEN_BITS'(2)) begin
                  crc_nxt = crc_byte(crc_r, held0_r);
                  held0_nxt = held1_r;
                  emit = 1'b1;
                  ekind = KIND_DATA;
                  ebyte = held0_r;
                end
              end
            end
          end
        end
        PH_LAST: begin
          flag_nxt = 8'd0;
          bcnt_nxt = 4'd0;
        end
        PH_TAIL: begin
          flag_nxt = flag_sh;
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= 4'd8) begin
            bcnt_nxt = 4'd0;
            if (flag_sh != FLAG_OCTET) flag_nxt = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    if (step && emit) begin
      okind_r <= ekind;
      obyte_r <= ebyte;
      olen_r <= elen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      flag_r <= 8'd0;
      bcnt_r <= 4'd0;
      ones_r <= 3'd0;
      asm_r <= 8'd0;
      count_r <= '0;
      crc_r <= CRC_INIT;
      ovalid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      flag_r <= flag_nxt;
      bcnt_r <= bcnt_nxt;
      ones_r <= ones_nxt;
      asm_r <= asm_nxt;
      count_r <= count_nxt;
      crc_r <= crc_nxt;
      if (step && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_kind = okind_r;
  assign out_data_byte = obyte_r;
  assign out_frame_length = olen_r;

endmodule

[rtl/hdlc_bit_deframer_unit.sv]
`timescale 1ns / 1ps
// Top level of the HDLC bit deframer: register block, decoding front end,
// bit queue and framer back end. Depends on hbd_pkg and the hbd_* modules.
//
//   Channel  Direction  Handshake            Beat
//   in       input      in_valid/in_ready    one raw line bit
//   out      output     out_valid/out_ready  one data byte or frame end report
//   cfg      input      APB psel/penable     one register write or read
//
// One bit is taken per cycle while in_ready is high; the framer retires one queued bit per cycle
// unless the result beat is stalled, so the sustained rate is one bit per clock while out_ready stays high.
// A result reaches the registered result beat after its bit has passed through the queue,
// and is taken at an edge where out_ready is high.
// Reset is synchronous and active low and clears all control state at once.
// When the output is stalled the four-entry queue absorbs bits, then in_ready drops.
module hdlc_bit_deframer_unit import hbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_line_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_frame_length
);

  cfg_t      cfg;
  bit_beat_t push;
  bit_beat_t head;
  logic      queue_full;
  logic      pop;

  hbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hbd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .scramble_enable (cfg.scramble_enable),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_line_bit     (in_line_bit),
    .queue_full      (queue_full),
    .push            (push)
  );

  hbd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (queue_full),
    .head  (head)
  );

  hbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length)
  );

endmodule

[rtl/hbd_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the HDLC bit deframer and its bind to the top level.
// Depends on hbd_pkg for the result kinds.
module hbd_checker import hbd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [11:0] out_frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_data_byte) && $stable(out_frame_length))
    else $error("Result beat changed while stalled.");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("Input not ready after reset.");

  a_data_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_frame_length == 12'd0)
    else $error("Data beat carries a frame length.");

  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_data_byte == 8'd0)
    else $error("End beat carries a data byte.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_GOOD
      || out_kind == KIND_BAD_CRC || out_kind == KIND_SHORT
      || out_kind == KIND_OVERFLOW))
    else $error("Result kind code undefined.");

endmodule

bind hdlc_bit_deframer_unit hbd_checker u_hbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_data_byte    (out_data_byte),
  .out_frame_length (out_frame_length)
);

[sim/hdlc_bit_deframer_checker.sv]
`timescale 1ns / 1ps
// Checker for the HDLC bit deframer: follows register writes, predicts every result
// beat from the accepted line bits and compares it field by field, plus register reads.
// Depends on hbd_pkg; also holds the small FCS helper package used by the stimulus.
package hbd_tb_pkg;
  import hbd_pkg::*;

  function automatic logic [15:0] fcs16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

module hdlc_bit_deframer_checker import hbd_pkg::*, hbd_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_line_bit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [11:0] out_frame_length,
  output int          mismatch_count,
  output int          awaited_count
);

  typedef struct {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [11:0] frame_length;
  } frame_event_t;

  frame_event_t frame_events[$];
  int mismatches = 0;

  logic        cfg_scramble;
  logic [11:0] cfg_min_bytes;
  logic [11:0] cfg_max_bytes;

  logic [16:0] lfsr;
  logic        last_level;
  phase_t      phase;
  logic [7:0]  octet_window;
  int unsigned bit_idx;
  int unsigned ones;
  logic [7:0]  octet_acc;
  int unsigned bytes_seen;
  logic [7:0]  held [2];
  logic [15:0] fcs_acc;

  assign mismatch_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [11:0] payload_count(input int unsigned n);
    return (n >= 2) ? 12'(n - 2) : 12'd0;
  endfunction

  task automatic queue_event(input kind_t k, input logic [7:0] d, input logic [11:0] len);
    frame_event_t e;
    e.kind = k;
    e.data_byte = d;
    e.frame_length = len;
    frame_events.push_back(e);
  endtask

  task automatic deframe_line_bit(input logic line);
    logic d;
    logic r;
    logic [7:0] b;
    int unsigned n;
    d = line;
    if (cfg_scramble) begin
      d = line ^ lfsr[11] ^ lfsr[16];
      lfsr = {lfsr[15:0], line};
    end
    r = (last_level == d);
    last_level = d;
    case (phase)
      PH_HUNT: begin
        octet_window = {r, octet_window[7:1]};
        if (octet_window == FLAG_OCTET) begin
          phase = PH_FLAGS;
          bit_idx = 0;
        end
      end
      PH_FLAGS: begin
        octet_window = {r, octet_window[7:1]};
        bit_idx++;
        if (bit_idx == 8) begin
          bit_idx = 0;
          if (octet_window != FLAG_OCTET) begin
            phase = PH_DATA;
            held[0] = octet_window;
            bytes_seen = 1;
            ones = 0;
            octet_acc = 8'h00;
            fcs_acc = CRC_INIT;
          end
        end
      end
      PH_DATA: begin
        if (ones >= 5) begin
          ones = 0;
          if (r) begin
            phase = PH_LAST;
            if (bytes_seen < 2 || bytes_seen < cfg_min_bytes) begin
              queue_event(KIND_SHORT, 8'h00, payload_count(bytes_seen));
            end else if ({held[1], held[0]} == ~fcs_acc) begin
              queue_event(KIND_GOOD, 8'h00, payload_count(bytes_seen));
            end else begin
              queue_event(KIND_BAD_CRC, 8'h00, payload_count(bytes_seen));
            end
          end
        end else begin
          ones = r ? ones + 1 : 0;
          octet_acc = {r, octet_acc[7:1]};
          bit_idx++;
          if (bit_idx == 8) begin
            b = octet_acc;
            n = bytes_seen + 1;
            bit_idx = 0;
            octet_acc = 8'h00;
            if (n > cfg_max_bytes || n > (1 << LEN_BITS) - 1) begin
              queue_event(KIND_OVERFLOW, 8'h00, payload_count(bytes_seen));
              phase = PH_HUNT;
              octet_window = 8'h00;
              ones = 0;
            end else if (bytes_seen >= 2) begin
              queue_event(KIND_DATA, held[0], 12'd0);
              fcs_acc = fcs16_step(fcs_acc, held[0]);
              held[0] = held[1];
              held[1] = b;
              bytes_seen = n;
            end else begin
              held[1] = b;
              bytes_seen = n;
            end
          end
        end
      end
      PH_LAST: begin
        phase = PH_TAIL;
        octet_window = 8'h00;
        bit_idx = 0;
      end
      default: begin
        octet_window = {r, octet_window[7:1]};
        bit_idx++;
        if (bit_idx >= 8) begin
          bit_idx = 0;
          if (octet_window != FLAG_OCTET) begin
            phase = PH_HUNT;
            octet_window = 8'h00;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    frame_event_t e;
    logic [31:0] reg_value;
    logic        mapped;
    if (!rst_n) begin
      cfg_scramble = 1'b0;
      cfg_min_bytes = MIN_FRAME_RESET;
      cfg_max_bytes = MAX_FRAME_RESET;
      lfsr = '0;
      last_level = 1'b0;
      phase = PH_HUNT;
      octet_window = 8'h00;
      bit_idx = 0;
      ones = 0;
      octet_acc = 8'h00;
      bytes_seen = 0;
      held[0] = 8'h00;
      held[1] = 8'h00;
      fcs_acc = CRC_INIT;
      frame_events.delete();
    end else begin
      if (psel && penable && pready) begin
        mapped = 1'b1;
        reg_value = 32'd0;
        case (paddr[3:2])
          REG_SCRAMBLE_ENABLE: reg_value = {31'd0, cfg_scramble};
          REG_MIN_FRAME_BYTES: reg_value = {20'd0, cfg_min_bytes};
          REG_MAX_FRAME_BYTES: reg_value = {20'd0, cfg_max_bytes};
          default: mapped = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_SCRAMBLE_ENABLE: cfg_scramble = pwdata[0];
            REG_MIN_FRAME_BYTES: cfg_min_bytes = pwdata[11:0];
            REG_MAX_FRAME_BYTES: cfg_max_bytes = pwdata[11:0];
            default: ;
          endcase
        end else if (mapped && prdata !== reg_value) begin
          report_mismatch($sformatf("register at %0h reads %0h, want %0h",
                                    paddr, prdata, reg_value));
        end
      end
      if (in_valid && in_ready) begin
        deframe_line_bit(in_line_bit);
      end
      if (out_valid && out_ready) begin
        if (frame_events.size() == 0) begin
          report_mismatch($sformatf("result beat kind %0d with nothing awaited", out_kind));
        end else begin
          e = frame_events.pop_front();
          if (out_kind !== e.kind) begin
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, e.kind));
          end
          if (out_data_byte !== e.data_byte) begin
            report_mismatch($sformatf("data_byte %0h, want %0h", out_data_byte, e.data_byte));
          end
          if (out_frame_length !== e.frame_length) begin
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      out_frame_length, e.frame_length));
          end
        end
      end
    end
    awaited_count <= frame_events.size();
  end

endmodule

[sim/hdlc_bit_deframer_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for hdlc_bit_deframer_unit: encodes HDLC frames into NRZI and
// optionally scrambled line bits, drives the register port and gives the verdict.
// Depends on hbd_pkg, hbd_tb_pkg and hdlc_bit_deframer_checker.
module hdlc_bit_deframer_unit_test;
  import hbd_pkg::*;
  import hbd_tb_pkg::*;

  typedef enum {
    MODE_CLEAN,
    MODE_BAD_FCS,
    MODE_BIT_ERROR,
    MODE_ABORT,
    MODE_NOISE
  } frame_mode_t;

  localparam logic [3:0] SPARE_ADDR = 4'hC;
  localparam logic [7:0] IDLE_OCTET = 8'hFF;
  localparam logic [7:0] ABORT_OCTET = 8'hFF;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_BITS = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_line_bit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [11:0] out_frame_length;
  int          mismatch_total;
  int          awaited;

  logic [16:0] tx_lfsr = '0;
  logic        tx_level = 1'b0;
  logic        tx_scramble = 1'b0;
  int          stuff_ones = 0;
  int          bit_serial = 0;
  int          flip_at = -1;
  int          gap_pct = 0;
  int          stall_pct = 15;
  int          line_bits_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;

  hdlc_bit_deframer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_line_bit(in_line_bit),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_frame_length(out_frame_length)
  );

  hdlc_bit_deframer_checker watch (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_line_bit(in_line_bit),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_frame_length(out_frame_length),
    .mismatch_count(mismatch_total), .awaited_count(awaited)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_line(input logic raw);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_bit <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    line_bits_sent++;
  endtask

  task automatic send_raw(input logic raw);
    if (tx_scramble) begin
      tx_level = raw ^ tx_lfsr[11] ^ tx_lfsr[16];
      tx_lfsr = {tx_lfsr[15:0], raw};
    end else begin
      tx_level = raw;
    end
    push_line(raw);
  endtask

  task automatic send_bit(input logic d);
    logic v;
    logic lvl;
    v = (bit_serial == flip_at) ? ~d : d;
    bit_serial++;
    lvl = v ? tx_level : ~tx_level;
    send_raw(tx_scramble ? (lvl ^ tx_lfsr[11] ^ tx_lfsr[16]) : lvl);
  endtask

  task automatic send_octet(input logic [7:0] b, input bit stuffed);
    for (int k = 0; k < 8; k++) begin
      send_bit(b[k]);
      if (stuffed) begin
        stuff_ones = b[k] ? stuff_ones + 1 : 0;
        if (stuff_ones == 5) begin
          send_bit(1'b0);
          stuff_ones = 0;
        end
      end
    end
  endtask

  task automatic send_frame(input logic [7:0] octets[$], input int abort_at);
    bit cut;
    cut = 1'b0;
    repeat ($urandom_range(1, 3)) send_octet(FLAG_OCTET, 1'b0);
    send_octet(octets[0], 1'b0);
    stuff_ones = 0;
    for (int i = 1; i < octets.size() && !cut; i++) begin
      if (i == abort_at) begin
        send_octet(ABORT_OCTET, 1'b0);
        cut = 1'b1;
      end else begin
        send_octet(octets[i], 1'b1);
      end
    end
    if (!cut) begin
      send_octet(FLAG_OCTET, 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_octet(FLAG_OCTET, 1'b0);
    repeat ($urandom_range(1, 2)) send_octet(IDLE_OCTET, 1'b0);
  endtask

  task automatic send_payload(input logic [7:0] payload[$], input frame_mode_t mode);
    logic [7:0]  octets[$];
    logic [15:0] acc;
    logic [15:0] fcs;
    int          abort_at;
    acc = CRC_INIT;
    octets = payload;
    foreach (payload[i]) acc = fcs16_step(acc, payload[i]);
    fcs = ~acc;
    if (mode == MODE_BAD_FCS) begin
      fcs ^= 16'($urandom_range(1, 65535));
    end
    octets.push_back(fcs[7:0]);
    octets.push_back(fcs[15:8]);
    abort_at = (mode == MODE_ABORT) ? $urandom_range(1, octets.size() - 1) : 0;
    if (mode == MODE_BIT_ERROR) begin
      flip_at = bit_serial + $urandom_range(8, 9 * octets.size() + 16);
    end
    send_frame(octets, abort_at);
    flip_at = -1;
  endtask

  task automatic send_random_traffic();
    logic [7:0]  payload[$];
    int          n;
    int          pick;
    bit          all_ones;
    frame_mode_t mode;
    pick = $urandom_range(0, 99);
    n = (pick < 70) ? $urandom_range(0, 6) : (pick < 95) ? $urandom_range(7, 20)
                                                          : $urandom_range(21, 40);
    all_ones = ($urandom_range(0, 9) == 0);
    repeat (n) payload.push_back(all_ones ? 8'hFF : 8'($urandom()));
    pick = $urandom_range(0, 99);
    mode = (pick < 70) ? MODE_CLEAN : (pick < 78) ? MODE_BAD_FCS :
           (pick < 86) ? MODE_BIT_ERROR : (pick < 93) ? MODE_ABORT : MODE_NOISE;
    case ($urandom_range(0, 2))
      0: gap_pct = 0;
      1: gap_pct = 5;
      default: gap_pct = 25;
    endcase
    if (mode == MODE_NOISE) begin
      repeat ($urandom_range(1, 40)) send_raw(1'($urandom_range(0, 1)));
    end else begin
      send_payload(payload, mode);
    end
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = line_bits_sent;
    while (line_bits_sent - start < budget) send_random_traffic();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [3:0] reg_addr(input reg_index_t idx);
    return {idx, 2'b00};
  endfunction

  task automatic read_back_all();
    cfg_access(1'b0, reg_addr(REG_SCRAMBLE_ENABLE), 32'd0);
    cfg_access(1'b0, reg_addr(REG_MIN_FRAME_BYTES), 32'd0);
    cfg_access(1'b0, reg_addr(REG_MAX_FRAME_BYTES), 32'd0);
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [11:0] value, input int width);
    logic [31:0] data;
    data = ($urandom() << width) | 32'(value);
    cfg_access(1'b1, reg_addr(idx), data);
    cfg_access(1'b0, reg_addr(idx), 32'd0);
    if (idx == REG_SCRAMBLE_ENABLE) begin
      tx_scramble = value[0];
    end
  endtask

  initial begin : result_side
    forever begin
      if (!hold_done && line_bits_sent >= HOLD_AFTER_BITS) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] p[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_back_all();

    gap_pct = 0;
    p = {8'h00, 8'hFF, 8'h7E, 8'h80, 8'h01};
    repeat (6) p.push_back(8'($urandom()));
    send_payload(p, MODE_CLEAN);
    p.pop_back();
    send_payload(p, MODE_CLEAN);
    p.push_back(8'h5A);
    p.push_back(8'hC3);
    send_payload(p, MODE_BAD_FCS);
    p = {8'h12, 8'h34, 8'h56};
    send_payload(p, MODE_ABORT);
    settle();

    set_reg(REG_SCRAMBLE_ENABLE, 12'd1, 1);
    set_reg(REG_MIN_FRAME_BYTES, 12'd3, 12);
    set_reg(REG_MAX_FRAME_BYTES, 12'd4095, 12);
    p = {};
    send_payload(p, MODE_CLEAN);
    p = {8'hE7};
    send_payload(p, MODE_CLEAN);
    p = {8'hA5};
    send_frame(p, 0);
    p = {8'hFF, 8'hFF, 8'h7E};
    send_payload(p, MODE_CLEAN);
    run_phase(80);
    settle();

    set_reg(REG_SCRAMBLE_ENABLE, 12'd0, 1);
    set_reg(REG_MAX_FRAME_BYTES, 12'd3, 12);
    cfg_access(1'b1, SPARE_ADDR, $urandom());
    read_back_all();
    run_phase(60);
    settle();

    set_reg(REG_SCRAMBLE_ENABLE, 12'd1, 1);
    set_reg(REG_MIN_FRAME_BYTES, 12'd4095, 12);
    set_reg(REG_MAX_FRAME_BYTES, 12'd20, 12);
    run_phase(60);
    settle();

    set_reg(REG_SCRAMBLE_ENABLE, 12'd0, 1);
    set_reg(REG_MIN_FRAME_BYTES, 12'd0, 12);
    set_reg(REG_MAX_FRAME_BYTES, 12'd0, 12);
    run_phase(50);
    settle();

    set_reg(REG_SCRAMBLE_ENABLE, 12'($urandom_range(0, 1)), 1);
    set_reg(REG_MIN_FRAME_BYTES, 12'($urandom_range(3, 8)), 12);
    set_reg(REG_MAX_FRAME_BYTES, 12'($urandom_range(8, 40)), 12);
    quiet = 1'b1;
    run_phase(80);
    settle();

    if (mismatch_total == 0 && awaited == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
